/* rtl/bpol_pkg.sv */
// ----------------------------------------------------------------------------
// bpol_pkg
// Shared constants and types for the block peak output limiter.
// ----------------------------------------------------------------------------
package bpol_pkg;

    localparam int GAIN_FRAC = 16;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int CEIL_W    = 23;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(GAIN_FRAC + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC;
    localparam logic [CEIL_W-1:0] CEIL_RESET = CEIL_W'(4194304);
    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(65535);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_CEILING = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_RELEASE = t_cfg_idx'(1);

endpackage

/* rtl/block_peak_output_limiter.sv */
// While a block fills, an input is accepted each cycle i_in_valid is high. At
// block end: divider (only if the peak exceeds the ceiling), gain step, release
// update (if the gain is not lowered). Each output sample then passes buffer
// read, shared multiply, rounding and output transfer, which waits on i_out_ready.
// Reset (synchronous, i_rst_n low): empty buffer, zero peak, unity gain,
// ceiling 4194304, release coefficient 65535.
// ----------------------------------------------------------------------------
// block_peak_output_limiter
// Buffers one block of samples, tracks its peak, derives a limiting gain with
// instant attack and exponential release, then drains the scaled block.
// ----------------------------------------------------------------------------
module block_peak_output_limiter #(
    parameter int BLOCK_DEPTH = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  bpol_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [bpol_pkg::CEIL_W-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                     i_sample_invalid,
    input  logic                     i_last_in_block,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                     o_last_out
);
    import bpol_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int FC_W  = $clog2(BLOCK_DEPTH + 1);
    localparam int CMP_W = (SB > CEIL_W) ? SB : CEIL_W;
    localparam int A_W   = (SB > GAIN_W) ? SB : GAIN_W;
    localparam int PW    = A_W + GAIN_W;
    localparam int RM_W  = PW - GAIN_FRAC;

    localparam logic [PW-1:0]   HALF    = PW'(1) << (GAIN_FRAC - 1);
    localparam logic [RM_W-1:0] MAX_POS = RM_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [RM_W-1:0] MAX_NEG = RM_W'(64'd1 << (SB - 1));

    typedef enum logic [3:0] {
        ST_FILL,
        ST_DIV,
        ST_GAIN,
        ST_REL,
        ST_REL_UPD,
        ST_RD,
        ST_MUL,
        ST_RND,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic [CEIL_W-1:0]   r_ceiling;
    logic [COEF_W-1:0]   r_coef;
    logic [FC_W-1:0]     r_fill;
    logic [SB-1:0]       r_peak;
    logic [GAIN_W-1:0]   r_gain;
    logic [GAIN_W-1:0]   r_target;
    logic [AW-1:0]       r_last_idx;
    logic [AW-1:0]       r_rd_idx;
    logic [PW-1:0]       r_prod;
    logic                r_neg;
    logic                r_inv;
    logic                r_out_valid;
    logic [SB-1:0]       r_out_sample;
    logic                r_out_last;

    logic [SB:0]         mem [0:BLOCK_DEPTH-1];
    logic [SB:0]         r_rd_data;

    logic                in_xfer;
    logic                out_xfer;
    logic                blk_end;
    logic [SB-1:0]       in_mag;
    logic [SB-1:0]       rd_mag;
    logic [CMP_W-1:0]    ceil_ext;
    logic [CMP_W-1:0]    peak_ext;
    logic                over;
    logic [GAIN_W-1:0]   deficit;
    logic [A_W-1:0]      mul_a;
    logic [GAIN_W-1:0]   mul_b;
    logic [PW-1:0]       rnd;
    logic [RM_W-1:0]     rmag;
    logic [RM_W-1:0]     lim_pos;
    logic [RM_W-1:0]     lim_neg;
    logic [SB-1:0]       out_val;
    logic                div_start;
    logic                div_done;
    logic [GAIN_FRAC-1:0] div_quot;
    logic [SB-1:0]       peak_next;
    logic                peak_over;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    assign blk_end  = i_last_in_block || (r_fill == FC_W'(BLOCK_DEPTH - 1));

    assign in_mag = i_sample_in[SB-1] ? (~i_sample_in + SB'(1)) : i_sample_in;
    assign rd_mag = r_rd_data[SB-1] ? (~r_rd_data[SB-1:0] + SB'(1)) : r_rd_data[SB-1:0];

    assign ceil_ext = CMP_W'(r_ceiling);
    assign peak_ext = CMP_W'(r_peak);
    assign over     = peak_ext > ceil_ext;

    assign deficit = GAIN_ONE - r_gain;
    assign mul_a   = (r_state == ST_REL) ? A_W'(deficit) : A_W'(rd_mag);
    assign mul_b   = (r_state == ST_REL) ? GAIN_W'(r_coef) : r_gain;

    assign rnd     = r_prod + HALF;
    assign rmag    = rnd[PW-1:GAIN_FRAC];
    assign lim_pos = (rmag > MAX_POS) ? MAX_POS : rmag;
    assign lim_neg = (rmag > MAX_NEG) ? MAX_NEG : rmag;
    assign out_val = r_inv ? '0 :
                     r_neg ? (~lim_neg[SB-1:0] + SB'(1)) : lim_pos[SB-1:0];

    assign div_start = in_xfer && blk_end && (over || (CMP_W'(in_mag) > ceil_ext
                       && !i_sample_invalid));

    assign peak_next = (!i_sample_invalid && in_mag > r_peak) ? in_mag : r_peak;
    assign peak_over = CMP_W'(peak_next) > ceil_ext;

    bpol_div #(
        .W (SB)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ceil_ext[SB-1:0]),
        .i_divisor  (peak_next),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            mem[r_fill[AW-1:0]] <= {i_sample_invalid, i_sample_in};
        end
        r_rd_data <= mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ceiling   <= CEIL_RESET;
            r_coef      <= COEF_RESET;
            r_fill      <= '0;
            r_peak      <= '0;
            r_gain      <= GAIN_ONE;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_CEILING: r_ceiling <= i_cfg_wdata;
                    CFG_RELEASE: r_coef    <= i_cfg_wdata[COEF_W-1:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_FILL: begin
                    if (in_xfer) begin
                        r_fill <= r_fill + FC_W'(1);
                        r_peak <= peak_next;
                        if (blk_end) begin
                            r_last_idx <= r_fill[AW-1:0];
                            r_target   <= GAIN_ONE;
                            r_state    <= peak_over ? ST_DIV : ST_GAIN;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_target <= GAIN_W'(div_quot);
                        r_state  <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    if (r_target < r_gain) begin
                        r_gain  <= r_target;
                        r_state <= ST_RD;
                    end else begin
                        r_state <= ST_REL;
                    end
                    r_rd_idx <= '0;
                end
                ST_REL: begin
                    r_prod  <= PW'(mul_a) * PW'(mul_b);
                    r_state <= ST_REL_UPD;
                end
                ST_REL_UPD: begin
                    r_gain  <= GAIN_ONE - GAIN_W'(r_prod[GAIN_FRAC +: GAIN_FRAC]);
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_prod  <= PW'(mul_a) * PW'(mul_b);
                    r_neg   <= r_rd_data[SB-1];
                    r_inv   <= r_rd_data[SB];
                    r_state <= ST_RND;
                end
                ST_RND: begin
                    r_out_sample <= out_val;
                    r_out_last   <= (r_rd_idx == r_last_idx);
                    r_out_valid  <= 1'b1;
                    r_state      <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_fill  <= '0;
                            r_peak  <= '0;
                            r_state <= ST_FILL;
                        end else begin
                            r_rd_idx <= r_rd_idx + AW'(1);
                            r_state  <= ST_RD;
                        end
                    end
                end
                default: r_state <= ST_FILL;
            endcase
        end
    end

    assign o_in_ready   = (r_state == ST_FILL);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last_out   = r_out_last;

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while output pending");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_ONE)
        else $error("gain above unity");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FC_W'(BLOCK_DEPTH))
        else $error("fill count overflow");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_out) |=> o_in_ready)
        else $error("input not reopened after last transfer");
`endif

endmodule

/* rtl/bpol_div.sv */
// ----------------------------------------------------------------------------
// bpol_div
// Restoring divider, one quotient bit per cycle. Computes
// floor(dividend * 2^GAIN_FRAC / divisor) for dividend < divisor.
// ----------------------------------------------------------------------------
module bpol_div #(
    parameter int W = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [W-1:0]                    i_dividend,
    input  logic [W-1:0]                    i_divisor,
    output logic                            o_done,
    output logic [bpol_pkg::GAIN_FRAC-1:0]  o_quot
);
    import bpol_pkg::*;

    logic [W-1:0]         r_rem;
    logic [W-1:0]         r_div;
    logic [GAIN_FRAC-1:0] r_quot;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [W:0] rem_sh;
    logic [W:0] rem_sub;
    logic       take;

    assign rem_sh  = {r_rem, 1'b0};
    assign rem_sub = rem_sh - {1'b0, r_div};
    assign take    = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(GAIN_FRAC);
                r_rem  <= i_dividend;
                r_div  <= i_divisor;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= take ? rem_sub[W-1:0] : rem_sh[W-1:0];
                r_quot <= {r_quot[GAIN_FRAC-2:0], take};
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
